FILE: src/http_fixdate_to_epoch_seconds_unit_assert.svh
// Assertion macros for the HTTP fixdate to epoch seconds unit.
// Used by the top level; depends on nothing else.
`ifndef HTTP_FIXDATE_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH
`define HTTP_FIXDATE_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define HFE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hfe assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfe assertion failed");

`else

`define HFE_ASSERT_SAME(label, ante, cons)
`define HFE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/hfe_pkg.sv
// Shared types, constants and helper functions for the HTTP fixdate unit.
// Used by the parser, the pipeline and the top level; depends on nothing.
package hfe_pkg;

    // Queue depths (powers of two).
    localparam int REC_QUEUE_DEPTH = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    // Character positions inside "Www, DD Mmm YYYY HH:MM:SS GMT".
    localparam logic [4:0] POS_WDAY_0  = 5'd0;
    localparam logic [4:0] POS_WDAY_1  = 5'd1;
    localparam logic [4:0] POS_WDAY_2  = 5'd2;
    localparam logic [4:0] POS_COMMA   = 5'd3;
    localparam logic [4:0] POS_SP_A    = 5'd4;
    localparam logic [4:0] POS_DAY_HI  = 5'd5;
    localparam logic [4:0] POS_DAY_LO  = 5'd6;
    localparam logic [4:0] POS_SP_B    = 5'd7;
    localparam logic [4:0] POS_MON_0   = 5'd8;
    localparam logic [4:0] POS_MON_1   = 5'd9;
    localparam logic [4:0] POS_MON_2   = 5'd10;
    localparam logic [4:0] POS_SP_C    = 5'd11;
    localparam logic [4:0] POS_YEAR_0  = 5'd12;
    localparam logic [4:0] POS_YEAR_1  = 5'd13;
    localparam logic [4:0] POS_YEAR_2  = 5'd14;
    localparam logic [4:0] POS_YEAR_3  = 5'd15;
    localparam logic [4:0] POS_SP_D    = 5'd16;
    localparam logic [4:0] POS_HOUR_HI = 5'd17;
    localparam logic [4:0] POS_HOUR_LO = 5'd18;
    localparam logic [4:0] POS_COLON_A = 5'd19;
    localparam logic [4:0] POS_MIN_HI  = 5'd20;
    localparam logic [4:0] POS_MIN_LO  = 5'd21;
    localparam logic [4:0] POS_COLON_B = 5'd22;
    localparam logic [4:0] POS_SEC_HI  = 5'd23;
    localparam logic [4:0] POS_SEC_LO  = 5'd24;
    localparam logic [4:0] POS_SP_E    = 5'd25;
    localparam logic [4:0] POS_G       = 5'd26;
    localparam logic [4:0] POS_M       = 5'd27;
    localparam logic [4:0] POS_T       = 5'd28;
    localparam logic [4:0] POS_SAT     = 5'd30;

    // Character codes.
    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_COLON = 16'h003A;
    localparam logic [15:0] CH_ZERO  = 16'h0030;
    localparam logic [15:0] CH_NINE  = 16'h0039;
    localparam logic [15:0] CH_G     = 16'h0047;
    localparam logic [15:0] CH_M     = 16'h004D;
    localparam logic [15:0] CH_T     = 16'h0054;
    localparam logic [15:0] CH_UP_A  = 16'h0041;
    localparam logic [15:0] CH_UP_Z  = 16'h005A;
    localparam logic [15:0] CASE_GAP = 16'h0020;

    // Calendar arithmetic constants.
    localparam logic [13:0] ERA_YEARS         = 14'd400;
    localparam logic [23:0] DAYS_EPOCH_OFFSET = 24'd865565;
    localparam logic [16:0] SEC_PER_DAY       = 17'd86400;
    localparam logic [16:0] SEC_PER_HOUR      = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN       = 17'd60;
    localparam logic [21:0] DAYS_PER_YEAR     = 22'd365;
    localparam logic [24:0] DIV25_MUL         = 25'd5243;
    localparam logic [3:0]  MONTH_FEB         = 4'd2;
    localparam logic [3:0]  MONTH_NONE        = 4'd0;

    // Lowercase month names, first letter in the top byte.
    localparam logic [23:0] MONTH_NAMES [12] = '{
        24'h6A616E, 24'h666562, 24'h6D6172, 24'h617072,
        24'h6D6179, 24'h6A756E, 24'h6A756C, 24'h617567,
        24'h736570, 24'h6F6374, 24'h6E6F76, 24'h646563
    };

    // One parsed date, handed from the front to the back.
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } date_rec_t;

    // One finished result.
    typedef struct packed {
        logic               date_valid;
        logic signed [38:0] epoch_seconds;
    } result_t;

    // Lowercase only the letters A to Z.
    function automatic logic [15:0] lower_ascii(input logic [15:0] c);
        logic [15:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

    // Month number 1..12 from three lowercased letters, zero if no match.
    function automatic logic [3:0] month_index(input logic [15:0] a, input logic [15:0] b,
                                               input logic [15:0] c);
        logic [3:0] m;
        m = MONTH_NONE;
        for (int i = 0; i < 12; i++)
        begin
            if (a == {8'h00, MONTH_NAMES[i][23:16]} && b == {8'h00, MONTH_NAMES[i][15:8]} &&
                c == {8'h00, MONTH_NAMES[i][7:0]})
            begin
                m = 4'(i + 1);
            end
        end
        return m;
    endfunction

    // Days from March 1 to the first of the month, in a March-based year.
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/hfe_fifo.sv
// Small synchronous queue with a count, used between the stages of the unit.
// Depends on nothing; DEPTH must be a power of two of at least two.
module hfe_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage is written without reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/hfe_front.sv
// Character parser: checks the fixdate layout and gathers the date fields.
// Depends on hfe_pkg; emits one date record per string.
module hfe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    input  logic [15:0]       char_code,
    input  logic              last_char,
    output logic              rec_push,
    output hfe_pkg::date_rec_t rec
);

    logic [4:0]  pos_reg,    pos_next;
    logic        fok_reg,    fok_next;
    logic [6:0]  day_reg,    day_next;
    logic [6:0]  hour_reg,   hour_next;
    logic [6:0]  min_reg,    min_next;
    logic [6:0]  sec_reg,    sec_next;
    logic [13:0] year_reg,   year_next;
    logic [47:0] month_reg,  month_next;
    logic        is_digit;
    logic [3:0]  digit;
    logic [3:0]  month_num;

    assign is_digit  = (char_code >= hfe_pkg::CH_ZERO) && (char_code <= hfe_pkg::CH_NINE);
    assign digit     = char_code[3:0];
    assign month_num = hfe_pkg::month_index(hfe_pkg::lower_ascii(month_reg[15:0]),
                                            hfe_pkg::lower_ascii(month_reg[31:16]),
                                            hfe_pkg::lower_ascii(month_reg[47:32]));

    // Per-character check and accumulation.
    always_comb
    begin
        pos_next   = pos_reg;
        fok_next   = fok_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        year_next  = year_reg;
        month_next = month_reg;
        unique case (pos_reg)
            hfe_pkg::POS_WDAY_0, hfe_pkg::POS_WDAY_1, hfe_pkg::POS_WDAY_2:
            begin
            end
            hfe_pkg::POS_COMMA:
            begin
                if (char_code != hfe_pkg::CH_COMMA) fok_next = 1'b0;
            end
            hfe_pkg::POS_SP_A, hfe_pkg::POS_SP_B, hfe_pkg::POS_SP_C, hfe_pkg::POS_SP_D,
            hfe_pkg::POS_SP_E:
            begin
                if (char_code != hfe_pkg::CH_SPACE) fok_next = 1'b0;
            end
            hfe_pkg::POS_COLON_A, hfe_pkg::POS_COLON_B:
            begin
                if (char_code != hfe_pkg::CH_COLON) fok_next = 1'b0;
            end
            hfe_pkg::POS_G:
            begin
                if (char_code != hfe_pkg::CH_G) fok_next = 1'b0;
            end
            hfe_pkg::POS_M:
            begin
                if (char_code != hfe_pkg::CH_M) fok_next = 1'b0;
            end
            hfe_pkg::POS_T:
            begin
                if (char_code != hfe_pkg::CH_T) fok_next = 1'b0;
            end
            hfe_pkg::POS_DAY_HI, hfe_pkg::POS_DAY_LO:
            begin
                if (is_digit) day_next = 7'(day_reg * 7'd10 + 7'(digit));
                else          fok_next = 1'b0;
            end
            hfe_pkg::POS_HOUR_HI, hfe_pkg::POS_HOUR_LO:
            begin
                if (is_digit) hour_next = 7'(hour_reg * 7'd10 + 7'(digit));
                else          fok_next  = 1'b0;
            end
            hfe_pkg::POS_MIN_HI, hfe_pkg::POS_MIN_LO:
            begin
                if (is_digit) min_next = 7'(min_reg * 7'd10 + 7'(digit));
                else          fok_next = 1'b0;
            end
            hfe_pkg::POS_SEC_HI, hfe_pkg::POS_SEC_LO:
            begin
                if (is_digit) sec_next = 7'(sec_reg * 7'd10 + 7'(digit));
                else          fok_next = 1'b0;
            end
            hfe_pkg::POS_YEAR_0, hfe_pkg::POS_YEAR_1, hfe_pkg::POS_YEAR_2,
            hfe_pkg::POS_YEAR_3:
            begin
                if (is_digit) year_next = 14'(year_reg * 14'd10 + 14'(digit));
                else          fok_next  = 1'b0;
            end
            hfe_pkg::POS_MON_0:
            begin
                month_next[15:0] = char_code;
            end
            hfe_pkg::POS_MON_1:
            begin
                month_next[31:16] = char_code;
            end
            hfe_pkg::POS_MON_2:
            begin
                month_next[47:32] = char_code;
            end
            default:
            begin
                // Anything past the last position makes the string too long.
                fok_next = 1'b0;
            end
        endcase
        if (pos_reg < hfe_pkg::POS_SAT)
        begin
            pos_next = pos_reg + 5'd1;
        end
    end

    // The record is built from the completed fields on the last character.
    always_comb
    begin
        rec_push   = char_valid && last_char;
        rec.ok     = fok_next && (pos_reg == hfe_pkg::POS_T) &&
                     (month_num != hfe_pkg::MONTH_NONE) &&
                     (day_reg >= 7'd1) && (day_reg <= 7'd31) && (hour_reg <= 7'd23) &&
                     (min_reg <= 7'd59) && (sec_reg <= 7'd59);
        rec.year   = year_reg;
        rec.month  = month_num;
        rec.day    = day_reg;
        rec.hour   = hour_reg;
        rec.minute = min_reg;
        rec.second = sec_reg;
    end

    // Parser state; returns to its reset value after the last character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            fok_reg   <= 1'b1;
            day_reg   <= '0;
            hour_reg  <= '0;
            min_reg   <= '0;
            sec_reg   <= '0;
            year_reg  <= '0;
            month_reg <= '0;
        end
        else if (char_valid)
        begin
            if (last_char)
            begin
                pos_reg   <= '0;
                fok_reg   <= 1'b1;
                day_reg   <= '0;
                hour_reg  <= '0;
                min_reg   <= '0;
                sec_reg   <= '0;
                year_reg  <= '0;
                month_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                fok_reg   <= fok_next;
                day_reg   <= day_next;
                hour_reg  <= hour_next;
                min_reg   <= min_next;
                sec_reg   <= sec_next;
                year_reg  <= year_next;
                month_reg <= month_next;
            end
        end
    end

endmodule

FILE: src/hfe_back.sv
// Four-stage pipeline that turns a date record into signed Unix seconds.
// Depends on hfe_pkg; the whole pipeline holds while stage 4 holds a result and the result queue is full.
module hfe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_avail,
    input  hfe_pkg::date_rec_t rec,
    output logic               rec_pop,
    input  logic               out_full,
    output logic               res_push,
    output hfe_pkg::result_t   res
);

    logic               adv;
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    // Stage 1: shifted year, day of year, time of day.
    logic               s1_ok_reg;
    logic [13:0]        s1_year_reg;
    logic [8:0]         s1_doy_reg;
    logic [16:0]        s1_tod_reg;
    logic [13:0]        s1_year_next;
    logic [8:0]         s1_doy_next;
    logic [16:0]        s1_tod_next;

    // Stage 2: year terms.
    logic               s2_ok_reg;
    logic [21:0]        s2_y365_reg;
    logic [11:0]        s2_q4_reg;
    logic [7:0]         s2_q100_reg;
    logic [7:0]         s2_q400_reg;
    logic [8:0]         s2_doy_reg;
    logic [16:0]        s2_tod_reg;
    logic [24:0]        q100_prod;
    logic [24:0]        q400_prod;

    // Stage 3: day count.
    logic               s3_ok_reg;
    logic signed [23:0] s3_days_reg;
    logic [16:0]        s3_tod_reg;
    logic [23:0]        s3_days_next;

    // Stage 4: seconds.
    hfe_pkg::result_t   s4_res_reg;
    logic signed [17:0] sec_per_day_s;
    logic signed [41:0] day_secs;
    logic [38:0]        secs_sum;

    assign adv      = !(s4_valid_reg && out_full);
    assign rec_pop  = adv && rec_avail;
    assign res_push = s4_valid_reg && !out_full;
    assign res      = s4_res_reg;

    // Stage 1 logic: the year starts in March, shifted by one era to stay positive.
    always_comb
    begin
        s1_year_next = rec.year + hfe_pkg::ERA_YEARS -
                       14'((rec.month <= hfe_pkg::MONTH_FEB) ? 1 : 0);
        s1_doy_next  = hfe_pkg::month_offset(rec.month) + 9'(rec.day) - 9'd1;
        s1_tod_next  = 17'(rec.hour) * hfe_pkg::SEC_PER_HOUR +
                       17'(rec.minute) * hfe_pkg::SEC_PER_MIN + 17'(rec.second);
    end

    // Stage 2 logic: divisions by 100 and 400 as a multiply by 1/25 after a shift.
    assign q100_prod = 25'(s1_year_reg[13:2]) * hfe_pkg::DIV25_MUL;
    assign q400_prod = 25'(s1_year_reg[13:4]) * hfe_pkg::DIV25_MUL;

    // Stage 3 logic: civil day count relative to 1970-01-01.
    assign s3_days_next = 24'(s2_y365_reg) + 24'(s2_q4_reg) - 24'(s2_q100_reg) +
                          24'(s2_q400_reg) + 24'(s2_doy_reg) - hfe_pkg::DAYS_EPOCH_OFFSET;

    // Stage 4 logic: one signed multiply and the time-of-day add.
    assign sec_per_day_s = $signed({1'b0, hfe_pkg::SEC_PER_DAY});
    assign day_secs      = s3_days_reg * sec_per_day_s;
    assign secs_sum      = day_secs[38:0] + 39'(s3_tod_reg);

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= rec_avail;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ok_reg   <= rec.ok;
            s1_year_reg <= s1_year_next;
            s1_doy_reg  <= s1_doy_next;
            s1_tod_reg  <= s1_tod_next;

            s2_ok_reg   <= s1_ok_reg;
            s2_y365_reg <= 22'(s1_year_reg) * hfe_pkg::DAYS_PER_YEAR;
            s2_q4_reg   <= s1_year_reg[13:2];
            s2_q100_reg <= q100_prod[24:17];
            s2_q400_reg <= q400_prod[24:17];
            s2_doy_reg  <= s1_doy_reg;
            s2_tod_reg  <= s1_tod_reg;

            s3_ok_reg   <= s2_ok_reg;
            s3_days_reg <= $signed(s3_days_next);
            s3_tod_reg  <= s2_tod_reg;

            s4_res_reg.date_valid    <= s3_ok_reg;
            s4_res_reg.epoch_seconds <= s3_ok_reg ? $signed(secs_sum) : '0;
        end
    end

endmodule

FILE: src/http_fixdate_to_epoch_seconds_unit.sv
// HTTP IMF-fixdate to Unix time converter, top level.
// Depends on hfe_pkg, hfe_fifo, hfe_front, hfe_back and the assertion header.
//
// Usage: characters of a date string arrive one per transaction on the input
// queue (push/full, char_code, last_char); last_char marks the final one.
// Each string produces exactly one result transaction on the output queue
// (empty/pop, date_valid, epoch_seconds); epoch_seconds is zero when the
// string is not a well-formed 29-character IMF-fixdate.
// Throughput: one character per cycle while full is low. The parser handles
// each character in the cycle it is accepted, and a four-stage arithmetic
// pipeline converts one finished date per cycle unless it holds on a full
// result queue. A finished date passes through the record queue, the four
// pipeline stages and the result queue, in that order.
// A record queue of REC_DEPTH entries separates the parser from the pipeline.
// When the receiver stops popping, the result queue fills, the pipeline holds,
// then the record queue fills and full rises; no transaction is lost.
// Reset clears the parser state and the pipeline valid bits and empties both queues.
`include "http_fixdate_to_epoch_seconds_unit_assert.svh"

module http_fixdate_to_epoch_seconds_unit #(
    parameter int REC_DEPTH = hfe_pkg::REC_QUEUE_DEPTH,
    parameter int OUT_DEPTH = hfe_pkg::OUT_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        char_code,
    input  logic               last_char,
    output logic               empty,
    input  logic               pop,
    output logic               date_valid,
    output logic signed [38:0] epoch_seconds
);

    logic               char_accept;
    logic               rec_push;
    hfe_pkg::date_rec_t rec_in;
    hfe_pkg::date_rec_t rec_head;
    logic               rec_full;
    logic               rec_empty;
    logic               rec_pop;
    logic               res_push;
    hfe_pkg::result_t   res_in;
    hfe_pkg::result_t   res_head;
    logic               out_full;

    assign full          = rec_full;
    assign char_accept   = push && !rec_full;
    assign date_valid    = res_head.date_valid;
    assign epoch_seconds = res_head.epoch_seconds;

    // Front: layout check and field capture.
    hfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_accept),
        .char_code  (char_code),
        .last_char  (last_char),
        .rec_push   (rec_push),
        .rec        (rec_in)
    );

    // Record queue between the parser and the arithmetic.
    hfe_fifo #(
        .DEPTH (REC_DEPTH),
        .WIDTH ($bits(hfe_pkg::date_rec_t))
    ) u_rec_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec_in),
        .rd_en   (rec_pop),
        .rd_data (rec_head),
        .full    (rec_full),
        .empty   (rec_empty)
    );

    // Back: calendar arithmetic.
    hfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_avail (!rec_empty),
        .rec       (rec_head),
        .rec_pop   (rec_pop),
        .out_full  (out_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result queue toward the receiver.
    hfe_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(hfe_pkg::result_t))
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_head),
        .full    (out_full),
        .empty   (empty)
    );

    // An invalid date always carries zero seconds.
    `HFE_ASSERT_SAME(a_invalid_zero, !empty && !date_valid, epoch_seconds == 39'sd0)
    // A valid date lies between year 0 and the end of year 9999.
    `HFE_ASSERT_SAME(a_valid_range, !empty && date_valid,
        (epoch_seconds >= -39'sd62167219200) && (epoch_seconds <= 39'sd253402300799))
    // The input side can only become full after a record was queued.
    `HFE_ASSERT_NEXT(a_full_needs_record, !rec_push && !full, !full)

endmodule
